>>> rtl/core/moving_average_filter_core_assert.svh
// Assertion macros shared by the moving average filter RTL.
// Each macro expands to one labelled concurrent assertion on clk, held off during reset.
`ifndef MOVING_AVERAGE_FILTER_CORE_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MAF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/maf_pkg.sv
package maf_pkg;

    // Width of one sample and of one average.
    localparam int SAMPLE_W = 16;

    // Width of the window size register and the largest value it can hold.
    localparam int WS_W   = 7;
    localparam int WS_MAX = (1 << WS_W) - 1;

    // Default depth of the sample store.
    localparam int DEF_MAX_WINDOW = 64;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from the word address.
    localparam logic REG_WINDOW_SIZE = 1'b0;

endpackage

>>> rtl/core/maf_ram.sv
module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/moving_average_filter_core.sv
// Boxcar moving average filter. Each sample transaction on the slave stream is written into a
// circular store of MAX_WINDOW entries and the running sum of the last window_size samples is
// divided by window_size, truncated toward zero, to give one average transaction on the master
// stream. Samples not yet written since reset or since the last window_size write count as zero.
// A window_size of 0 turns the filter off: every sample gives an average of 0 and is not stored.
// Values above MAX_WINDOW act as MAX_WINDOW. Writing window_size empties the window; it must only
// be written while the block is idle. After acceptance, a sample first updates the store and the
// running sum, then passes through the restoring divider that produces one quotient bit per
// cycle, and finally loads the output register once the output is free. The next sample can be
// taken from the cycle after the average is loaded, never while one is in flight. With the filter
// off a sample goes straight from acceptance to the output register. No clearing pass follows
// reset: the store is read as zero until the write position has wrapped once, so the block is
// ready straight away.
module moving_average_filter_core #(
    parameter int MAX_WINDOW = maf_pkg::DEF_MAX_WINDOW
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // Sample stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [maf_pkg::SAMPLE_W-1:0]   s_tdata,   // [15:0] sample (signed)

    // Average stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [maf_pkg::SAMPLE_W-1:0]   m_tdata,   // [15:0] average (signed)

    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [maf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [maf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [maf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    import maf_pkg::*;

    `include "moving_average_filter_core_assert.svh"

    // Store addressing and arithmetic widths follow the store depth.
    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = SAMPLE_W + ADDR_W + 1;
    localparam int MAG_W  = SUM_W - 1;
    localparam int CNT_W  = $clog2(MAG_W);
    localparam int CMP_W  = (ADDR_W + 1 > WS_W) ? ADDR_W + 1 : WS_W;
    localparam int CLAMP  = (MAX_WINDOW > WS_MAX) ? WS_MAX : MAX_WINDOW;

    localparam logic [WS_W-1:0]  N_MAX    = WS_W'(CLAMP);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [WS_W-1:0]         ws_reg;
    logic [ADDR_W-1:0]       pos_reg;
    logic [ADDR_W-1:0]       pos_next;
    logic                    wrapped_reg;
    logic                    wrapped_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;

    // Payload registers, no reset needed.
    logic [SAMPLE_W-1:0]     sample_reg;
    logic [SAMPLE_W-1:0]     sample_next;
    logic [MAG_W-1:0]        dq_reg;
    logic [MAG_W-1:0]        dq_next;
    logic [WS_W-1:0]         rem_reg;
    logic [WS_W-1:0]         rem_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic [SAMPLE_W-1:0]     m_data_reg;
    logic [SAMPLE_W-1:0]     m_data_next;

    logic                    cfg_write;
    logic                    s_accept;
    logic                    out_free;
    logic [WS_W-1:0]         n_eff;
    logic [SAMPLE_W-1:0]     ram_rdata;
    logic [SAMPLE_W-1:0]     old_sample;
    logic signed [SUM_W-1:0] sum_upd;
    logic [SUM_W-1:0]        sum_abs;
    logic [ADDR_W:0]         pos_inc;
    logic [WS_W:0]           rem_shift;
    logic                    rem_ge;
    logic [SAMPLE_W-1:0]     q_low;

    // The configuration register is written in the access phase; reads are side-effect free.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);
    assign prdata    = (paddr[2] == REG_WINDOW_SIZE) ? APB_DATA_W'(ws_reg) : '0;

    // A window larger than the store acts as the full store.
    assign n_eff = (ws_reg > N_MAX) ? N_MAX : ws_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The read address is always the write position, so the entry about to be overwritten
    // is on the read port in the cycle after the sample is accepted.
    maf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (state_reg == ST_RD),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // An entry holds a real sample only once the position has gone round the window once.
    assign old_sample = wrapped_reg ? ram_rdata : '0;

    assign sum_upd = sum_reg
                   + {{(SUM_W - SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg}
                   - {{(SUM_W - SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
    assign sum_abs = sum_upd[SUM_W-1] ? (~sum_upd + 1'b1) : sum_upd;
    assign pos_inc = {1'b0, pos_reg} + 1'b1;

    // One restoring division step: bring in the next dividend bit and try the divisor.
    assign rem_shift = {rem_reg, dq_reg[MAG_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, n_eff});

    // The quotient never exceeds 2^15, so its low bits carry the whole result.
    assign q_low = dq_reg[SAMPLE_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        wrapped_next = wrapped_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        sample_next  = sample_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    sample_next = s_tdata;
                    if (n_eff == '0)
                    begin
                        // Filter off: a zero quotient with no sign gives an average of 0.
                        dq_next    = '0;
                        neg_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                sum_next = sum_upd;
                if (CMP_W'(pos_inc) >= CMP_W'(n_eff))
                begin
                    pos_next     = '0;
                    wrapped_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_inc[ADDR_W-1:0];
                end
                dq_next    = sum_abs[MAG_W-1:0];
                neg_next   = sum_upd[SUM_W-1];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_ge)
                begin
                    rem_next = WS_W'(rem_shift - {1'b0, n_eff});
                end
                else
                begin
                    rem_next = rem_shift[WS_W-1:0];
                end
                dq_next  = {dq_reg[MAG_W-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_data_next  = neg_reg ? (~q_low + 1'b1) : q_low;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A window size write empties the window; the user must issue it while idle, unchecked.
        if (cfg_write)
        begin
            pos_next     = '0;
            wrapped_next = 1'b0;
            sum_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ws_reg      <= '0;
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            wrapped_reg <= wrapped_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write)
            begin
                ws_reg <= pwdata[WS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        m_data_reg <= m_data_next;
    end

    // While the filter is on, the write position always lies inside the active window.
    `MAF_ASSERT_SAME(a_pos_in_window, n_eff != '0,
                     CMP_W'(pos_reg) < CMP_W'(n_eff),
                     "write position outside window")

    // An accepted sample with the filter on always goes through the store update next.
    `MAF_ASSERT_NEXT(a_accept_to_rd, s_accept && (n_eff != '0),
                     state_reg == ST_RD,
                     "accepted sample skipped store update")

    // The store update is followed by the divider, never by another acceptance.
    `MAF_ASSERT_NEXT(a_rd_to_div, state_reg == ST_RD,
                     (state_reg == ST_DIV) && !s_tready,
                     "store update not followed by division")

    // A window size write leaves an empty window.
    `MAF_ASSERT_NEXT(a_cfg_clears, cfg_write,
                     (sum_reg == '0) && (pos_reg == '0) && !wrapped_reg,
                     "window not cleared by configuration write")

endmodule
